[sv/qty_pkg.sv]
// Shared types, widths and constants for the quaternion yaw unit.
// No dependencies; every other file in this folder refers to it by scoped names.
package qty_pkg;

   // Component and product widths
   localparam int COMP_W = 16;
   localparam int PROD_W = 2 * COMP_W;
   localparam int WIDE_W = PROD_W + 2;
   localparam int NORM_W = PROD_W + 1;
   localparam int THR_W = 16;
   localparam int TN_W = THR_W + NORM_W;
   localparam int CMP_W = WIDE_W + THR_W + 1;

   // CORDIC datapath; the normaliser leaves the larger magnitude in [2^39, 2^40)
   localparam int CORDIC_W = 44;
   localparam int NORM_BIT = 40;
   localparam int ITERATIONS = 16;
   localparam int ATAN_IDX_W = 5;
   localparam int SHIFT_LOG = 5;
   localparam int COARSE_STEPS = 3;
   localparam int ANGLE_W = 28;
   localparam int SCALED_W = ANGLE_W + 1;

   // Output formatting
   localparam int RAD_W = 16;
   localparam int DEG_W = 17;
   localparam int RAD_SHIFT = 12;
   localparam int DEG_SHIFT = 34;
   localparam int DEG_K_W = 23;
   localparam int DEG_PROD_W = ANGLE_W + DEG_K_W;
   localparam logic signed [ANGLE_W-1:0] PI_Q24 = 28'sd52707179;
   localparam logic signed [ANGLE_W-1:0] TWO_PI_Q24 = 28'sd105414357;
   localparam logic signed [DEG_K_W-1:0] DEG_K = 23'sd3754936;
   localparam logic [ANGLE_W-1:0] RAD_ROUND = ANGLE_W'(1) << (RAD_SHIFT - 1);
   localparam logic [DEG_PROD_W-1:0] DEG_ROUND = DEG_PROD_W'(1) << (DEG_SHIFT - 1);
   localparam logic signed [RAD_W-1:0] RAD_LIMIT = 16'sd25736;

   // Queue between front and back
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW = 3;
   localparam int FIFO_CW = FIFO_AW + 1;
   localparam int INFLIGHT_W = 3;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_GIMBAL_THRESHOLD = 1'b0;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      BRANCH_NORMAL = 2'd0,
      BRANCH_LOW    = 2'd1,
      BRANCH_HIGH   = 2'd2
   } qty_branch_type;

   // Classified item: branch and the atan2 operands
   typedef struct packed {
      qty_branch_type             branch;
      logic                       warn;
      logic signed [WIDE_W-1:0]   at_y;
      logic signed [WIDE_W-1:0]   at_x;
   } qty_item_type;

   // Result of the back end's angle stage
   typedef struct packed {
      qty_branch_type             branch;
      logic                       warn;
      logic signed [ANGLE_W-1:0]  angle;
   } qty_angle_type;

   // atan(2^-i) in Q.24 radians
   function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [ANGLE_W-1:0] v;
      unique case (idx)
         5'd0:  v = 28'sd13176795;
         5'd1:  v = 28'sd7778716;
         5'd2:  v = 28'sd4110060;
         5'd3:  v = 28'sd2086331;
         5'd4:  v = 28'sd1047214;
         5'd5:  v = 28'sd524117;
         5'd6:  v = 28'sd262123;
         5'd7:  v = 28'sd131069;
         5'd8:  v = 28'sd65536;
         5'd9:  v = 28'sd32768;
         5'd10: v = 28'sd16384;
         5'd11: v = 28'sd8192;
         5'd12: v = 28'sd4096;
         5'd13: v = 28'sd2048;
         5'd14: v = 28'sd1024;
         5'd15: v = 28'sd512;
         5'd16: v = 28'sd256;
         5'd17: v = 28'sd128;
         5'd18: v = 28'sd64;
         5'd19: v = 28'sd32;
         5'd20: v = 28'sd16;
         5'd21: v = 28'sd8;
         5'd22: v = 28'sd4;
         5'd23: v = 28'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[sv/qty_front.sv]
// Front end: accepts a quaternion, forms the products, norm and pitch term,
// and classifies the item into a yaw branch. Depends on qty_pkg.
module qty_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [qty_pkg::COMP_W-1:0]   quat_x,
   input  logic signed [qty_pkg::COMP_W-1:0]   quat_y,
   input  logic signed [qty_pkg::COMP_W-1:0]   quat_z,
   input  logic signed [qty_pkg::COMP_W-1:0]   quat_w,
   input  logic [qty_pkg::THR_W-1:0]           threshold,
   output logic                                out_valid,
   output qty_pkg::qty_item_type               out_item,
   output logic [qty_pkg::INFLIGHT_W-1:0]      inflight
);

   // Stage 1: products
   logic                                 s1_valid_ff;
   logic                                 s1_warn_ff, s1_warn_in;
   logic signed [qty_pkg::COMP_W-1:0]    s1_x_ff, s1_y_ff;
   logic signed [qty_pkg::PROD_W-1:0]    s1_xx_ff, s1_yy_ff, s1_zz_ff, s1_ww_ff;
   logic signed [qty_pkg::PROD_W-1:0]    s1_wy_ff, s1_xz_ff, s1_xy_ff, s1_wz_ff;
   logic signed [qty_pkg::PROD_W-1:0]    s1_xx_in, s1_yy_in, s1_zz_in, s1_ww_in;
   logic signed [qty_pkg::PROD_W-1:0]    s1_wy_in, s1_xz_in, s1_xy_in, s1_wz_in;

   // Stage 2: sums
   logic                                 s2_valid_ff;
   logic                                 s2_warn_ff;
   logic signed [qty_pkg::COMP_W-1:0]    s2_x_ff, s2_y_ff;
   logic [qty_pkg::NORM_W-1:0]           s2_norm_ff, s2_norm_in;
   logic signed [qty_pkg::WIDE_W-1:0]    s2_num_ff, s2_num_in;
   logic signed [qty_pkg::WIDE_W-1:0]    s2_yn_ff, s2_yn_in;
   logic signed [qty_pkg::WIDE_W-1:0]    s2_xn_ff, s2_xn_in;

   // Stage 3: threshold times norm
   logic                                 s3_valid_ff;
   logic                                 s3_warn_ff;
   logic signed [qty_pkg::COMP_W-1:0]    s3_x_ff, s3_y_ff;
   logic                                 s3_nz_ff, s3_nz_in;
   logic [qty_pkg::TN_W-1:0]             s3_tn_ff, s3_tn_in;
   logic signed [qty_pkg::WIDE_W-1:0]    s3_num_ff, s3_yn_ff, s3_xn_ff;

   // Stage 4: classification
   logic                                 s4_valid_ff;
   qty_pkg::qty_item_type                s4_item_ff, s4_item_in;
   logic signed [qty_pkg::CMP_W-1:0]     lhs, pos_tn, neg_tn;

   always_comb begin
      s1_warn_in = (quat_x != '0) && (quat_y != '0);
      s1_xx_in = quat_x * quat_x;
      s1_yy_in = quat_y * quat_y;
      s1_zz_in = quat_z * quat_z;
      s1_ww_in = quat_w * quat_w;
      s1_wy_in = quat_w * quat_y;
      s1_xz_in = quat_x * quat_z;
      s1_xy_in = quat_x * quat_y;
      s1_wz_in = quat_w * quat_z;
   end

   always_comb begin
      s2_norm_in = {1'b0, s1_xx_ff} + {1'b0, s1_yy_ff} + {1'b0, s1_zz_ff} + {1'b0, s1_ww_ff};
      s2_num_in = (qty_pkg::WIDE_W'(s1_wy_ff) - qty_pkg::WIDE_W'(s1_xz_ff)) <<< 1;
      s2_yn_in = (qty_pkg::WIDE_W'(s1_xy_ff) + qty_pkg::WIDE_W'(s1_wz_ff)) <<< 1;
      s2_xn_in = qty_pkg::WIDE_W'(s1_ww_ff) + qty_pkg::WIDE_W'(s1_xx_ff)
               - qty_pkg::WIDE_W'(s1_yy_ff) - qty_pkg::WIDE_W'(s1_zz_ff);
   end

   always_comb begin
      s3_tn_in = qty_pkg::TN_W'(threshold) * qty_pkg::TN_W'(s2_norm_ff);
      s3_nz_in = (s2_norm_ff != '0);
   end

   // Low case first: it wins when the pitch term and the threshold are both zero and the norm is nonzero
   always_comb begin
      lhs = qty_pkg::CMP_W'(s3_num_ff) <<< qty_pkg::THR_W;
      pos_tn = signed'(qty_pkg::CMP_W'(s3_tn_ff));
      neg_tn = -pos_tn;
      s4_item_in.warn = s3_warn_ff;
      s4_item_in.at_y = qty_pkg::WIDE_W'(s3_y_ff);
      s4_item_in.at_x = qty_pkg::WIDE_W'(s3_x_ff);
      priority if (s3_nz_ff && (lhs <= neg_tn)) begin
         s4_item_in.branch = qty_pkg::BRANCH_LOW;
      end else if (s3_nz_ff && (lhs >= pos_tn)) begin
         s4_item_in.branch = qty_pkg::BRANCH_HIGH;
      end else begin
         s4_item_in.branch = qty_pkg::BRANCH_NORMAL;
         s4_item_in.at_y = s3_yn_ff;
         s4_item_in.at_x = s3_xn_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_warn_ff <= s1_warn_in;
      s1_x_ff <= quat_x;
      s1_y_ff <= quat_y;
      s1_xx_ff <= s1_xx_in;
      s1_yy_ff <= s1_yy_in;
      s1_zz_ff <= s1_zz_in;
      s1_ww_ff <= s1_ww_in;
      s1_wy_ff <= s1_wy_in;
      s1_xz_ff <= s1_xz_in;
      s1_xy_ff <= s1_xy_in;
      s1_wz_ff <= s1_wz_in;

      s2_warn_ff <= s1_warn_ff;
      s2_x_ff <= s1_x_ff;
      s2_y_ff <= s1_y_ff;
      s2_norm_ff <= s2_norm_in;
      s2_num_ff <= s2_num_in;
      s2_yn_ff <= s2_yn_in;
      s2_xn_ff <= s2_xn_in;

      s3_warn_ff <= s2_warn_ff;
      s3_x_ff <= s2_x_ff;
      s3_y_ff <= s2_y_ff;
      s3_nz_ff <= s3_nz_in;
      s3_tn_ff <= s3_tn_in;
      s3_num_ff <= s2_num_ff;
      s3_yn_ff <= s2_yn_ff;
      s3_xn_ff <= s2_xn_ff;

      s4_item_ff <= s4_item_in;
   end

   assign out_valid = s4_valid_ff;
   assign out_item = s4_item_ff;
   assign inflight = qty_pkg::INFLIGHT_W'(s1_valid_ff) + qty_pkg::INFLIGHT_W'(s2_valid_ff)
                   + qty_pkg::INFLIGHT_W'(s3_valid_ff) + qty_pkg::INFLIGHT_W'(s4_valid_ff);

endmodule

[sv/qty_fifo.sv]
// Short queue of classified items between the front and back ends.
// Depends on qty_pkg for the item type and depth.
module qty_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  qty_pkg::qty_item_type            push_item,
   input  logic                             pop,
   output qty_pkg::qty_item_type            pop_item,
   output logic                             not_empty,
   output logic [qty_pkg::FIFO_CW-1:0]      count
);

   qty_pkg::qty_item_type               mem_ff [qty_pkg::FIFO_DEPTH];
   logic [qty_pkg::FIFO_AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [qty_pkg::FIFO_AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [qty_pkg::FIFO_CW-1:0]         count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + qty_pkg::FIFO_CW'(push) - qty_pkg::FIFO_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count = count_ff;

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != qty_pkg::FIFO_CW'(qty_pkg::FIFO_DEPTH)))
      else $error("queue written while full");

   a_drain_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not drop on read");
`endif

endmodule

[sv/qty_cordic.sv]
// Back end angle unit: quadrant pre-rotation, two-stage normaliser and a
// pipelined vectoring CORDIC giving atan2 in Q.24 radians. Depends on qty_pkg.
module qty_cordic (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  qty_pkg::qty_item_type     in_item,
   output logic                      out_valid,
   output qty_pkg::qty_angle_type    out_angle
);

   typedef struct packed {
      qty_pkg::qty_branch_type                branch;
      logic                                   warn;
      logic                                   zero;
      logic signed [qty_pkg::ANGLE_W-1:0]     base;
   } cordic_carry_type;

   function automatic logic [qty_pkg::CORDIC_W-1:0] mag(
      input logic signed [qty_pkg::CORDIC_W-1:0] v);
      return v[qty_pkg::CORDIC_W-1] ? qty_pkg::CORDIC_W'(-v) : qty_pkg::CORDIC_W'(v);
   endfunction

   // Pre-rotation
   logic                                 p_valid_ff;
   cordic_carry_type                     p_carry_ff, p_carry_in;
   logic signed [qty_pkg::CORDIC_W-1:0]  p_x_ff, p_x_in, p_y_ff, p_y_in;

   // Normaliser
   logic                                 n1_valid_ff, n2_valid_ff;
   cordic_carry_type                     n1_carry_ff, n2_carry_ff;
   logic signed [qty_pkg::CORDIC_W-1:0]  n1_x_ff, n1_x_in, n1_y_ff, n1_y_in;
   logic [qty_pkg::CORDIC_W-1:0]         n1_m_ff, n1_m_in, n2_m;
   logic signed [qty_pkg::CORDIC_W-1:0]  n2_x_ff, n2_x_in, n2_y_ff, n2_y_in;

   // Iterations
   logic                                 it_valid_ff [qty_pkg::ITERATIONS];
   cordic_carry_type                     it_carry_ff [qty_pkg::ITERATIONS];
   logic signed [qty_pkg::CORDIC_W-1:0]  it_x_ff [qty_pkg::ITERATIONS];
   logic signed [qty_pkg::CORDIC_W-1:0]  it_y_ff [qty_pkg::ITERATIONS];
   logic signed [qty_pkg::ANGLE_W-1:0]   it_z_ff [qty_pkg::ITERATIONS];
   logic signed [qty_pkg::CORDIC_W-1:0]  it_x_in [qty_pkg::ITERATIONS];
   logic signed [qty_pkg::CORDIC_W-1:0]  it_y_in [qty_pkg::ITERATIONS];
   logic signed [qty_pkg::ANGLE_W-1:0]   it_z_in [qty_pkg::ITERATIONS];

   // Final angle
   logic                                 a_valid_ff;
   qty_pkg::qty_angle_type               a_angle_ff, a_angle_in;

   // Fold the left half-plane onto the right; a zero sine term skips the rotation
   always_comb begin
      p_x_in = qty_pkg::CORDIC_W'(in_item.at_x);
      p_y_in = qty_pkg::CORDIC_W'(in_item.at_y);
      p_carry_in.branch = in_item.branch;
      p_carry_in.warn = in_item.warn;
      p_carry_in.zero = (in_item.at_y == '0);
      p_carry_in.base = '0;
      priority if (in_item.at_y == '0) begin
         p_carry_in.base = in_item.at_x[qty_pkg::WIDE_W-1] ? qty_pkg::PI_Q24 : '0;
      end else if (in_item.at_x[qty_pkg::WIDE_W-1]) begin
         p_carry_in.base = in_item.at_y[qty_pkg::WIDE_W-1] ? -qty_pkg::PI_Q24 : qty_pkg::PI_Q24;
         p_x_in = -p_x_in;
         p_y_in = -p_y_in;
      end else begin
         p_carry_in.base = '0;
      end
   end

   // Coarse shifts: 32, 16, 8
   always_comb begin
      n1_x_in = p_x_ff;
      n1_y_in = p_y_ff;
      n1_m_in = mag(p_x_ff) | mag(p_y_ff);
      for (int k = 0; k < qty_pkg::COARSE_STEPS; k++) begin
         if ((n1_m_in >> (qty_pkg::NORM_BIT - (1 << (qty_pkg::SHIFT_LOG - k)))) == '0) begin
            n1_m_in = n1_m_in << (1 << (qty_pkg::SHIFT_LOG - k));
            n1_x_in = n1_x_in <<< (1 << (qty_pkg::SHIFT_LOG - k));
            n1_y_in = n1_y_in <<< (1 << (qty_pkg::SHIFT_LOG - k));
         end
      end
   end

   // Fine shifts: 4, 2, 1
   always_comb begin
      n2_x_in = n1_x_ff;
      n2_y_in = n1_y_ff;
      n2_m = n1_m_ff;
      for (int k = qty_pkg::COARSE_STEPS; k <= qty_pkg::SHIFT_LOG; k++) begin
         if ((n2_m >> (qty_pkg::NORM_BIT - (1 << (qty_pkg::SHIFT_LOG - k)))) == '0) begin
            n2_m = n2_m << (1 << (qty_pkg::SHIFT_LOG - k));
            n2_x_in = n2_x_in <<< (1 << (qty_pkg::SHIFT_LOG - k));
            n2_y_in = n2_y_in <<< (1 << (qty_pkg::SHIFT_LOG - k));
         end
      end
   end

   for (genvar i = 0; i < qty_pkg::ITERATIONS; i++) begin : g_iter
      logic signed [qty_pkg::CORDIC_W-1:0]  x_src, y_src, xs, ys;
      logic signed [qty_pkg::ANGLE_W-1:0]   z_src, step;
      logic                                 v_src;
      cordic_carry_type                     c_src;

      if (i == 0) begin : g_first
         assign x_src = n2_x_ff;
         assign y_src = n2_y_ff;
         assign z_src = '0;
         assign v_src = n2_valid_ff;
         assign c_src = n2_carry_ff;
      end else begin : g_next
         assign x_src = it_x_ff[i-1];
         assign y_src = it_y_ff[i-1];
         assign z_src = it_z_ff[i-1];
         assign v_src = it_valid_ff[i-1];
         assign c_src = it_carry_ff[i-1];
      end

      assign xs = x_src >>> i;
      assign ys = y_src >>> i;
      assign step = qty_pkg::atan_entry(qty_pkg::ATAN_IDX_W'(i));
      assign it_x_in[i] = y_src[qty_pkg::CORDIC_W-1] ? x_src - ys : x_src + ys;
      assign it_y_in[i] = y_src[qty_pkg::CORDIC_W-1] ? y_src + xs : y_src - xs;
      assign it_z_in[i] = y_src[qty_pkg::CORDIC_W-1] ? z_src - step : z_src + step;

      always_ff @(posedge clock) begin
         if (reset) begin
            it_valid_ff[i] <= 1'b0;
         end else begin
            it_valid_ff[i] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         it_carry_ff[i] <= c_src;
         it_x_ff[i] <= it_x_in[i];
         it_y_ff[i] <= it_y_in[i];
         it_z_ff[i] <= it_z_in[i];
      end
   end

   always_comb begin
      a_angle_in.branch = it_carry_ff[qty_pkg::ITERATIONS-1].branch;
      a_angle_in.warn = it_carry_ff[qty_pkg::ITERATIONS-1].warn;
      a_angle_in.angle = it_carry_ff[qty_pkg::ITERATIONS-1].zero
                       ? it_carry_ff[qty_pkg::ITERATIONS-1].base
                       : it_carry_ff[qty_pkg::ITERATIONS-1].base
                         + it_z_ff[qty_pkg::ITERATIONS-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         n1_valid_ff <= 1'b0;
         n2_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= in_valid;
         n1_valid_ff <= p_valid_ff;
         n2_valid_ff <= n1_valid_ff;
         a_valid_ff <= it_valid_ff[qty_pkg::ITERATIONS-1];
      end
   end

   always_ff @(posedge clock) begin
      p_carry_ff <= p_carry_in;
      p_x_ff <= p_x_in;
      p_y_ff <= p_y_in;
      n1_carry_ff <= p_carry_ff;
      n1_x_ff <= n1_x_in;
      n1_y_ff <= n1_y_in;
      n1_m_ff <= n1_m_in;
      n2_carry_ff <= n1_carry_ff;
      n2_x_ff <= n2_x_in;
      n2_y_ff <= n2_y_in;
      a_angle_ff <= a_angle_in;
   end

   assign out_valid = a_valid_ff;
   assign out_angle = a_angle_ff;

`ifndef ASSERT_OFF
   // After the coarse shifts at most seven more doublings remain
   a_coarse_range: assert property (@(posedge clock) disable iff (reset)
      (n1_valid_ff && !n1_carry_ff.zero) |->
         ((n1_m_ff[qty_pkg::CORDIC_W-1:qty_pkg::NORM_BIT] == '0) &&
          (n1_m_ff[qty_pkg::NORM_BIT-1:qty_pkg::NORM_BIT-8] != '0)))
      else $error("normaliser coarse stage out of range");
`endif

endmodule

[sv/qty_finish.sv]
// Back end output stages: gimbal scaling, clamp to two pi, and rounding to
// radians (Q4.12) and degrees (Q11.6). Depends on qty_pkg.
module qty_finish (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  qty_pkg::qty_angle_type               in_angle,
   output logic                                 out_valid,
   output logic signed [qty_pkg::RAD_W-1:0]     yaw_radians,
   output logic signed [qty_pkg::DEG_W-1:0]     yaw_degrees,
   output qty_pkg::qty_branch_type              branch_taken,
   output logic                                 non_yaw_warning
);

   logic signed [qty_pkg::SCALED_W-1:0]    doubled, scaled;

   logic                                   f1_valid_ff, f2_valid_ff, f3_valid_ff;
   qty_pkg::qty_branch_type                f1_branch_ff, f2_branch_ff, f3_branch_ff;
   logic                                   f1_warn_ff, f2_warn_ff, f3_warn_ff;
   logic signed [qty_pkg::ANGLE_W-1:0]     f1_yaw_ff, f1_yaw_in;
   logic signed [qty_pkg::DEG_PROD_W-1:0]  f2_prod_ff, f2_prod_in;
   logic signed [qty_pkg::RAD_W-1:0]       f2_rad_ff, f2_rad_in, f3_rad_ff;
   logic signed [qty_pkg::DEG_W-1:0]       f3_deg_ff, f3_deg_in;
   logic signed [qty_pkg::ANGLE_W-1:0]     rad_sum;
   logic signed [qty_pkg::DEG_PROD_W-1:0]  deg_sum;

   always_comb begin
      doubled = qty_pkg::SCALED_W'(in_angle.angle) <<< 1;
      unique case (in_angle.branch)
         qty_pkg::BRANCH_NORMAL: scaled = qty_pkg::SCALED_W'(in_angle.angle);
         qty_pkg::BRANCH_LOW:    scaled = -doubled;
         qty_pkg::BRANCH_HIGH:   scaled = doubled;
         default:                scaled = qty_pkg::SCALED_W'(in_angle.angle);
      endcase
      priority if (scaled > qty_pkg::SCALED_W'(qty_pkg::TWO_PI_Q24)) begin
         f1_yaw_in = qty_pkg::TWO_PI_Q24;
      end else if (scaled < -qty_pkg::SCALED_W'(qty_pkg::TWO_PI_Q24)) begin
         f1_yaw_in = -qty_pkg::TWO_PI_Q24;
      end else begin
         f1_yaw_in = qty_pkg::ANGLE_W'(scaled);
      end
   end

   // Round half up on both outputs
   always_comb begin
      rad_sum = f1_yaw_ff + signed'(qty_pkg::RAD_ROUND);
      f2_rad_in = qty_pkg::RAD_W'(rad_sum >>> qty_pkg::RAD_SHIFT);
      f2_prod_in = qty_pkg::DEG_PROD_W'(f1_yaw_ff) * qty_pkg::DEG_PROD_W'(qty_pkg::DEG_K);
      deg_sum = f2_prod_ff + signed'(qty_pkg::DEG_ROUND);
      f3_deg_in = qty_pkg::DEG_W'(deg_sum >>> qty_pkg::DEG_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= in_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_branch_ff <= in_angle.branch;
      f1_warn_ff <= in_angle.warn;
      f1_yaw_ff <= f1_yaw_in;
      f2_branch_ff <= f1_branch_ff;
      f2_warn_ff <= f1_warn_ff;
      f2_prod_ff <= f2_prod_in;
      f2_rad_ff <= f2_rad_in;
      f3_branch_ff <= f2_branch_ff;
      f3_warn_ff <= f2_warn_ff;
      f3_rad_ff <= f2_rad_ff;
      f3_deg_ff <= f3_deg_in;
   end

   assign out_valid = f3_valid_ff;
   assign yaw_radians = f3_rad_ff;
   assign yaw_degrees = f3_deg_ff;
   assign branch_taken = f3_branch_ff;
   assign non_yaw_warning = f3_warn_ff;

`ifndef ASSERT_OFF
   a_rad_clamped: assert property (@(posedge clock) disable iff (reset)
      f3_valid_ff |-> ((f3_rad_ff <= qty_pkg::RAD_LIMIT) && (f3_rad_ff >= -qty_pkg::RAD_LIMIT)))
      else $error("yaw in radians beyond two pi");
`endif

endmodule

[sv/quaternion_to_yaw_unit.sv]
// Top level of the quaternion yaw unit: register port, front end, queue and back end.
// Depends on qty_pkg, qty_front, qty_fifo, qty_cordic and qty_finish.
//
// Usage:
//   Input: drive req_quat_x/y/z/w (signed Q1.15) and raise start; the item is
//   taken at a rising edge where start is high and busy is low. busy only rises
//   if the queue between front and back could overflow, which cannot happen
//   while results drain, so a new item may enter on every cycle.
//   Output: each result shows on the rsp_ ports for exactly one cycle with
//   rsp_valid high; the receiver has no way to hold it off. Results leave in
//   the order the items came in.
//   Pipeline: from the accepting edge an item passes four front stages, the
//   queue register, pre-rotation, two normaliser stages, sixteen CORDIC
//   iterations, the angle add and three output stages. Throughput is one item
//   per cycle while busy stays low, set by the pipelined CORDIC with one
//   iteration per stage.
//   Configuration: gimbal_threshold sits at byte address 0 of the APB-style
//   port and should be written while no item is in flight.
//   Reset (synchronous, active high) empties the pipeline and queue and
//   returns the threshold to 0xFFFF.
module quaternion_to_yaw_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic signed [qty_pkg::COMP_W-1:0]       req_quat_x,
   input  logic signed [qty_pkg::COMP_W-1:0]       req_quat_y,
   input  logic signed [qty_pkg::COMP_W-1:0]       req_quat_z,
   input  logic signed [qty_pkg::COMP_W-1:0]       req_quat_w,
   output logic                                    rsp_valid,
   output logic signed [qty_pkg::RAD_W-1:0]        rsp_yaw_radians,
   output logic signed [qty_pkg::DEG_W-1:0]        rsp_yaw_degrees,
   output logic [1:0]                              rsp_branch_taken,
   output logic                                    rsp_non_yaw_warning,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [qty_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [qty_pkg::CSR_DATA_W-1:0]          csr_pwdata,
   output logic [qty_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);

   logic [qty_pkg::THR_W-1:0]         threshold_ff, threshold_in;
   logic                              csr_hit;
   logic                              accept;

   logic                              fe_valid;
   qty_pkg::qty_item_type             fe_item;
   logic [qty_pkg::INFLIGHT_W-1:0]    fe_inflight;

   logic                              q_not_empty;
   qty_pkg::qty_item_type             q_item;
   logic [qty_pkg::FIFO_CW-1:0]       q_count;

   logic                              cd_valid;
   qty_pkg::qty_angle_type            cd_angle;
   qty_pkg::qty_branch_type           fin_branch;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_hit = (csr_paddr[qty_pkg::CSR_ADDR_W-1:2] == qty_pkg::REG_GIMBAL_THRESHOLD);

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         threshold_in = csr_pwdata[qty_pkg::THR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= qty_pkg::THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   assign csr_prdata = csr_hit ? qty_pkg::CSR_DATA_W'(threshold_ff) : '0;

   // Hold off new items once the queue could not take everything in flight
   assign busy = (q_count + qty_pkg::FIFO_CW'(fe_inflight))
                 >= qty_pkg::FIFO_CW'(qty_pkg::FIFO_DEPTH);
   assign accept = start && !busy;

   qty_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .quat_w    (req_quat_w),
      .threshold (threshold_ff),
      .out_valid (fe_valid),
      .out_item  (fe_item),
      .inflight  (fe_inflight)
   );

   qty_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_valid),
      .push_item (fe_item),
      .pop       (q_not_empty),
      .pop_item  (q_item),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   qty_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_not_empty),
      .in_item   (q_item),
      .out_valid (cd_valid),
      .out_angle (cd_angle)
   );

   qty_finish u_finish (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (cd_valid),
      .in_angle        (cd_angle),
      .out_valid       (rsp_valid),
      .yaw_radians     (rsp_yaw_radians),
      .yaw_degrees     (rsp_yaw_degrees),
      .branch_taken    (fin_branch),
      .non_yaw_warning (rsp_non_yaw_warning)
   );

   assign rsp_branch_taken = fin_branch;

endmodule
